>>> hdl/hashed_lru_block_cache_directory_macros.svh
// Assertion macros used by the cache directory top level.
`ifndef HASHED_LRU_BLOCK_CACHE_DIRECTORY_MACROS_SVH
`define HASHED_LRU_BLOCK_CACHE_DIRECTORY_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked on every clock edge outside reset.
`define HLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequence is checked in the next cycle.
`define HLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HLC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HLC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/hlcd_pkg.sv
// Package with the types, constants and functions of the cache directory.
package hlcd_pkg;

  localparam int unsigned BufferCount = 32;
  localparam int unsigned BucketCount = 13;
  localparam int unsigned NodeCount   = BufferCount + BucketCount;
  localparam int unsigned NodeW       = $clog2(NodeCount);
  localparam int unsigned BufW        = 5;
  localparam int unsigned BktW        = $clog2(BucketCount);
  localparam int unsigned StepW       = $clog2(BufferCount + 1);

  localparam logic [1:0] CmdGet     = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdPin     = 2'd2;
  localparam logic [1:0] CmdUnpin   = 2'd3;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatNoFree  = 2'd1;
  localparam logic [1:0] StatCount   = 2'd2;

  localparam logic [7:0] CountMax = 8'd255;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  dev;
    logic [31:0] block_number;
    logic [4:0]  buffer_index;
  } req_t;

  typedef struct packed {
    logic [4:0] granted_buffer;
    logic       was_hit;
    logic       needs_fill;
    logic [1:0] status;
  } rsp_t;

  // Head node of a bucket.
  function automatic logic [NodeW-1:0] head_of(input logic [BktW-1:0] b);
    head_of = NodeW'(BufferCount) + NodeW'(b);
  endfunction

  // Reset link of a node: forward or backward neighbor of the initial lists.
  // Buffers are appended at the head side in increasing index, so the head's
  // forward neighbor is the largest index of that bucket.
  function automatic logic [NodeW-1:0] reset_link(input int unsigned n, input bit fwd);
    int unsigned b, last, r;
    if (n >= BufferCount) begin
      b = n - BufferCount;
      last = NodeCount;
      for (int unsigned i = 0; i < BufferCount; i++) begin
        if (i % BucketCount == b) last = i;
      end
      if (last == NodeCount) begin
        r = n;
      end else if (fwd) begin
        r = last;
      end else begin
        r = b;
      end
    end else begin
      b = n % BucketCount;
      if (fwd) begin
        r = (n >= BucketCount) ? n - BucketCount : BufferCount + b;
      end else begin
        r = (n + BucketCount < BufferCount) ? n + BucketCount : BufferCount + b;
      end
    end
    reset_link = NodeW'(r);
  endfunction

endpackage

>>> hdl/hlcd_stream_if.sv
// Valid-ready channel interface used for requests and responses.
interface hlcd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/hashed_lru_block_cache_directory.sv
// Cache directory top level: request sequencer, tag store and recency links.
//
//  Channel | Dir | Payload
//  req     | in  | cmd, dev, block_number, buffer_index
//  rsp     | out | granted_buffer, was_hit, needs_fill, status
//
// A get hashes the key and walks its bucket one node a cycle; on a miss it
// walks the bucket lists for a free buffer, relinks one found in another
// bucket into the home bucket, then grants it and responds. Pin, unpin and
// release update the count; a release that reaches zero re-hashes and relinks.
// Walks read one link array each. After reset a pass loads the initial lists.
// The request side is not ready until the response register is empty again.
`include "hashed_lru_block_cache_directory_macros.svh"
module hashed_lru_block_cache_directory (
  input  logic          clk_i,
  input  logic          rst_ni,
  hlcd_stream_if.sink   req,
  hlcd_stream_if.source rsp
);
  localparam int unsigned NW = hlcd_pkg::NodeW;
  localparam int unsigned NC = hlcd_pkg::NodeCount;
  localparam int unsigned BC = hlcd_pkg::BufferCount;
  localparam int unsigned BW = hlcd_pkg::BufW;
  localparam int unsigned KW = hlcd_pkg::BktW;

  typedef enum logic [12:0] {
    StInit   = 13'b0000000000001,
    StIdle   = 13'b0000000000010,
    StHash   = 13'b0000000000100,
    StSearch = 13'b0000000001000,
    StFree   = 13'b0000000010000,
    StSteal  = 13'b0000000100000,
    StRelink = 13'b0000001000000,
    StHead   = 13'b0000010000000,
    StMove   = 13'b0000100000000,
    StLink   = 13'b0001000000000,
    StGrant  = 13'b0010000000000,
    StCount  = 13'b0100000000000,
    StResp   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  hlcd_pkg::req_t req_q;
  hlcd_pkg::rsp_t rsp_q, rsp_d;

  logic [NW-1:0] fwd_mem [NC];
  logic [NW-1:0] bwd_mem [NC];
  logic [NW-1:0] fwd_rd_q, bwd_rd_q;
  logic [NW-1:0] fwd_ra, bwd_ra, fwd_wa, bwd_wa, fwd_wd, bwd_wd;
  logic          fwd_we, bwd_we;
  logic [NW-1:0] init_fwd, init_bwd;

  logic [7:0]    tdev_q [BC];
  logic [31:0]   tblk_q [BC];
  logic [BC-1:0] cval_q;
  logic [7:0]    cnt_q [BC];

  logic [KW-1:0]              home_q, cur_q;
  logic [hlcd_pkg::StepW-1:0] steps_q;
  logic [KW-1:0]              tries_q;
  logic [BW-1:0]              pick_q;
  logic [NW-1:0]              lnk_q;
  logic [NW-1:0]              ini_q;
  logic                       release_q;

  logic          h_start, h_done;
  logic [KW-1:0] h_bucket;
  logic [32:0]   h_sum;
  logic          accept, rsp_valid_q;
  logic [BW-1:0] idx;
  logic [NW-1:0] head_cur, head_home, walk_node, pick_node;
  logic [BW-1:0] walk_buf;
  logic [KW-1:0] next_bkt;
  logic          node_is_buf, walk_end, tag_hit, is_free, last_try, rel_zero, idx_bad;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state_q == StIdle) && !rsp_valid_q;
  assign idx       = req_q.buffer_index;
  assign head_cur  = hlcd_pkg::head_of(cur_q);
  assign head_home = hlcd_pkg::head_of(home_q);
  assign pick_node = NW'(pick_q);
  assign rel_zero  = req_q.cmd == hlcd_pkg::CmdRelease && cnt_q[idx] == 8'd1;
  assign idx_bad   = {27'd0, req_q.buffer_index} >= 32'(BC);

  // Shared hash unit for gets and for releases that reach zero.
  assign h_start = (accept && req.payload.cmd == hlcd_pkg::CmdGet) ||
                   (state_q == StCount && !idx_bad && rel_zero);
  assign h_sum = (state_q == StCount)
                 ? 33'(tdev_q[idx]) + 33'(tblk_q[idx])
                 : 33'(req.payload.dev) + 33'(req.payload.block_number);

  hlcd_mod13 u_mod (
    .clk_i, .rst_ni, .start_i(h_start), .sum_i(h_sum),
    .done_o(h_done), .bucket_o(h_bucket)
  );

  // The search walks forward from the head, the free walk backward from it.
  assign walk_node   = (state_q == StSearch) ? fwd_rd_q : bwd_rd_q;
  assign walk_buf    = walk_node[BW-1:0];
  assign node_is_buf = walk_node < NW'(BC);
  assign walk_end    = (walk_node == head_cur) || !node_is_buf ||
                       (steps_q == hlcd_pkg::StepW'(BC));
  assign tag_hit     = tdev_q[walk_buf] == req_q.dev &&
                       tblk_q[walk_buf] == req_q.block_number;
  assign is_free     = cnt_q[walk_buf] == 8'd0;
  assign last_try    = tries_q == KW'(hlcd_pkg::BucketCount - 1);
  assign next_bkt    = (cur_q == KW'(hlcd_pkg::BucketCount - 1)) ? '0 : cur_q + KW'(1);

  // Initial link values, selected by the load counter.
  always_comb begin
    init_fwd = '0;
    init_bwd = '0;
    for (int unsigned k = 0; k < NC; k++) begin
      if (ini_q == NW'(k)) begin
        init_fwd = hlcd_pkg::reset_link(k, 1'b1);
        init_bwd = hlcd_pkg::reset_link(k, 1'b0);
      end
    end
  end

  // Link memory ports: one read and one write per list array a cycle.
  always_comb begin
    fwd_ra = head_home;
    bwd_ra = head_home;
    fwd_we = 1'b0;
    bwd_we = 1'b0;
    fwd_wa = pick_node;
    bwd_wa = pick_node;
    fwd_wd = '0;
    bwd_wd = '0;
    case (state_q)
      StInit: begin
        fwd_we = 1'b1;
        bwd_we = 1'b1;
        fwd_wa = ini_q;
        bwd_wa = ini_q;
        fwd_wd = init_fwd;
        bwd_wd = init_bwd;
      end
      StHash: begin
        fwd_ra = release_q ? NW'(idx) : hlcd_pkg::head_of(h_bucket);
        bwd_ra = NW'(idx);
      end
      StSearch: begin
        fwd_ra = walk_node;
        bwd_ra = head_cur;
      end
      StFree: begin
        if (walk_end) begin
          bwd_ra = hlcd_pkg::head_of(next_bkt);
        end else if (is_free) begin
          fwd_ra = walk_node;
          bwd_ra = walk_node;
        end else begin
          bwd_ra = walk_node;
        end
      end
      // Unlink the chosen buffer from its neighbors.
      StSteal, StRelink: begin
        fwd_we = 1'b1;
        bwd_we = 1'b1;
        fwd_wa = bwd_rd_q;
        fwd_wd = fwd_rd_q;
        bwd_wa = fwd_rd_q;
        bwd_wd = bwd_rd_q;
      end
      StHead: fwd_ra = head_home;
      // Own links: at the tail of home for a steal, after the head for release.
      StMove: begin
        fwd_we = 1'b1;
        bwd_we = 1'b1;
        fwd_wd = release_q ? fwd_rd_q : head_home;
        bwd_wd = release_q ? head_home : bwd_rd_q;
      end
      // Neighbor links that point to the inserted buffer.
      StLink: begin
        fwd_we = 1'b1;
        bwd_we = 1'b1;
        fwd_wa = release_q ? head_home : lnk_q;
        bwd_wa = release_q ? lnk_q : head_home;
        fwd_wd = pick_node;
        bwd_wd = pick_node;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
    if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
    fwd_rd_q <= fwd_mem[fwd_ra];
    bwd_rd_q <= bwd_mem[bwd_ra];
  end

  // Sequencer and response fields.
  always_comb begin
    state_d = state_q;
    rsp_d   = rsp_q;
    case (state_q)
      StInit:   if (ini_q == NW'(NC - 1)) state_d = StIdle;
      StIdle:   if (accept) begin
        rsp_d = '0;
        if (req.payload.cmd == hlcd_pkg::CmdGet) state_d = StHash;
        else state_d = StCount;
      end
      StHash:   if (h_done) state_d = release_q ? StRelink : StSearch;
      StSearch: begin
        if (walk_end) state_d = StFree;
        else if (tag_hit) begin
          rsp_d.granted_buffer = walk_buf;
          rsp_d.was_hit = 1'b1;
          rsp_d.needs_fill = !cval_q[walk_buf];
          rsp_d.status = (cnt_q[walk_buf] == hlcd_pkg::CountMax)
                         ? hlcd_pkg::StatCount : hlcd_pkg::StatOk;
          state_d = StResp;
        end
      end
      StFree: begin
        if (walk_end) begin
          if (last_try) begin
            rsp_d.status = hlcd_pkg::StatNoFree;
            state_d = StResp;
          end
        end else if (is_free) begin
          state_d = (cur_q == home_q) ? StGrant : StSteal;
        end
      end
      StSteal:  state_d = StMove;
      StRelink: state_d = StHead;
      StHead:   state_d = StMove;
      StMove:   state_d = StLink;
      StLink:   state_d = release_q ? StResp : StGrant;
      StGrant:  begin
        rsp_d.granted_buffer = pick_q;
        rsp_d.needs_fill = 1'b1;
        state_d = StResp;
      end
      StCount:  begin
        if (idx_bad) begin
          rsp_d.status = hlcd_pkg::StatCount;
          state_d = StResp;
        end else if (req_q.cmd == hlcd_pkg::CmdPin) begin
          if (cnt_q[idx] == hlcd_pkg::CountMax) rsp_d.status = hlcd_pkg::StatCount;
          state_d = StResp;
        end else if (cnt_q[idx] == 8'd0) begin
          rsp_d.status = hlcd_pkg::StatCount;
          state_d = StResp;
        end else if (rel_zero) begin
          state_d = StHash;
        end else begin
          state_d = StResp;
        end
      end
      StResp:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Control, walk registers and the tag stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      rsp_valid_q <= 1'b0;
      ini_q <= '0;
      req_q <= '0;
      for (int unsigned i = 0; i < BC; i++) begin
        tdev_q[i] <= '0;
        tblk_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      cval_q <= '0;
      release_q <= 1'b0;
      home_q <= '0;
      cur_q <= '0;
      steps_q <= '0;
      tries_q <= '0;
      pick_q <= '0;
      lnk_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StResp) rsp_valid_q <= 1'b1;
      else if (rsp.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        StInit: ini_q <= ini_q + NW'(1);
        StIdle: if (accept) begin
          req_q <= req.payload;
          release_q <= 1'b0;
        end
        StHash: if (h_done) begin
          home_q <= h_bucket;
          cur_q  <= h_bucket;
          steps_q <= '0;
          tries_q <= '0;
          if (release_q) pick_q <= idx;
        end
        StSearch: begin
          if (walk_end) begin
            steps_q <= '0;
          end else if (tag_hit) begin
            cval_q[walk_buf] <= 1'b1;
            if (cnt_q[walk_buf] != hlcd_pkg::CountMax)
              cnt_q[walk_buf] <= cnt_q[walk_buf] + 8'd1;
          end else begin
            steps_q <= steps_q + hlcd_pkg::StepW'(1);
          end
        end
        StFree: begin
          if (walk_end) begin
            cur_q <= next_bkt;
            tries_q <= tries_q + KW'(1);
            steps_q <= '0;
          end else if (is_free) begin
            pick_q <= walk_buf;
          end else begin
            steps_q <= steps_q + hlcd_pkg::StepW'(1);
          end
        end
        StMove: lnk_q <= release_q ? fwd_rd_q : bwd_rd_q;
        StGrant: begin
          tdev_q[pick_q] <= req_q.dev;
          tblk_q[pick_q] <= req_q.block_number;
          cnt_q[pick_q]  <= 8'd1;
          cval_q[pick_q] <= 1'b1;
        end
        StCount: if (!idx_bad) begin
          if (req_q.cmd == hlcd_pkg::CmdPin) begin
            if (cnt_q[idx] != hlcd_pkg::CountMax) cnt_q[idx] <= cnt_q[idx] + 8'd1;
          end else if (cnt_q[idx] != 8'd0) begin
            cnt_q[idx] <= cnt_q[idx] - 8'd1;
            if (rel_zero) release_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp.valid   = rsp_valid_q;
  assign rsp.payload = rsp_q;

  `HLC_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, req.ready, state_q == StIdle)
  `HLC_ASSERT_NXT(a_resp_valid, clk_i, rst_ni, state_q == StResp, rsp.valid)
  `HLC_ASSERT_IMP(a_hit_ok, clk_i, rst_ni, rsp.valid && rsp.payload.was_hit,
                  rsp.payload.status != hlcd_pkg::StatNoFree)
  `HLC_ASSERT_NXT(a_accept_leaves, clk_i, rst_ni, accept, state_q != StIdle)
  `HLC_ASSERT_IMP(a_bkt_range, clk_i, rst_ni, state_q == StFree,
                  cur_q < KW'(hlcd_pkg::BucketCount) && home_q < KW'(hlcd_pkg::BucketCount))
endmodule

>>> hdl/hlcd_mod13.sv
// Folding reduction of the 33-bit hash sum modulo the bucket count.
module hlcd_mod13 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [32:0]               sum_i,
  output logic                      done_o,
  output logic [hlcd_pkg::BktW-1:0] bucket_o
);
  logic [32:0] sum_q, sum_d;
  logic [13:0] fold_q, fold_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [27:0] prod;
  logic [11:0] quot;
  logic [11:0] rem;

  // 4096 is 1 modulo 13, so adding 12-bit chunks keeps the remainder.
  // Folding the chunks and then the carries back in brings the sum below 4096.
  always_comb begin
    sum_d  = sum_q;
    fold_d = fold_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      sum_d  = sum_i;
      cnt_d  = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      case (cnt_q)
        2'd0: fold_d = 14'(sum_q[11:0]) + 14'(sum_q[23:12]) + 14'(sum_q[32:24]);
        2'd1: fold_d = 14'(fold_q[11:0]) + 14'(fold_q[13:12]);
        2'd2: fold_d = 14'(fold_q[11:0]) + 14'(fold_q[12]);
        default: busy_d = 1'b0;
      endcase
      cnt_d = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    fold_q <= fold_d;
  end

  // Final remainder of a 12-bit value by a reciprocal multiply, exact below 4096.
  assign prod = 28'(fold_q[11:0]) * 28'(5042);
  assign quot = prod[27:16];
  assign rem  = fold_q[11:0] - quot * 12'd13;

  assign done_o   = busy_q && cnt_q == 2'd3 && !start_i;
  assign bucket_o = rem[hlcd_pkg::BktW-1:0];
endmodule
